// ----- rtl/sac_pkg.sv -----
`timescale 1ns / 1ps

package sac_pkg;

    // Widths of the raw readings, the register port and the results
    localparam int RAW_W = 12;
    localparam int OUT_W = 16;
    localparam int IN_TDATA_W = 24;
    localparam int OUT_TDATA_W = 2 * OUT_W;
    localparam int CFG_IDX_W = 3;

    // Default full-scale output value
    localparam int FULL_SCALE_DEF = 32767;

    // Register reset values
    localparam logic [RAW_W-1:0] CENTER_RST = 12'd2048;
    localparam logic [RAW_W-1:0] SPAN_RST = 12'd1400;
    localparam logic [RAW_W-1:0] BAND_RST = 12'd0;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_CENTER     = 3'd0,
        REG_Y_CENTER     = 3'd1,
        REG_X_SPAN_ABOVE = 3'd2,
        REG_X_SPAN_BELOW = 3'd3,
        REG_Y_SPAN_ABOVE = 3'd4,
        REG_Y_SPAN_BELOW = 3'd5,
        REG_DEAD_BAND    = 3'd6
    } t_reg_idx;

    // How an axis result is formed
    typedef enum logic [1:0] {
        K_ZERO = 2'd0,   // inside the dead band or no offset
        K_FULL = 2'd1,   // offset at or past the span, or span of zero
        K_DIV  = 2'd2    // scaled quotient from the divider
    } t_kind;

    // What one lane hands to the merging stage
    typedef struct packed {
        logic             neg;
        t_kind            kind;
        logic [OUT_W-1:0] quo;
    } t_axis_res;

endpackage

// ----- rtl/stick_axis_calibrate_deadzone_core.sv -----
`timescale 1ns / 1ps

// Two-axis stick calibration with dead band. Each request carries two packed
// 12-bit readings; each axis has its own lane that subtracts the center,
// zeroes offsets inside the dead band and otherwise forms
// trunc(offset * FULL_SCALE / span), saturated at plus or minus FULL_SCALE.
// One request is taken every clock cycle while the output side does not stall.
// QW = clog2(FULL_SCALE + 1) is the number of restoring divider steps in each
// lane. The stages are a classify stage, a multiply stage, QW divider stages
// and the output register. Stages advance independently, so bubbles collapse
// when the output side stalls. Registers must be written on the configuration
// channel only while no request is in flight; the block does not enforce this.

module stick_axis_calibrate_deadzone_core import sac_pkg::*; #(
    parameter int FULL_SCALE = FULL_SCALE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [7:0] byte_low, [15:8] byte_mid,
                                                     // [23:16] byte_high
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // [15:0] x_out, [31:16] y_out
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [RAW_W-1:0]       i_cfg_data
);

    localparam int QW = $clog2(FULL_SCALE + 1);
    localparam int DEP = QW + 2;

    logic [RAW_W-1:0] r_x_center;
    logic [RAW_W-1:0] r_y_center;
    logic [RAW_W-1:0] r_x_span_above;
    logic [RAW_W-1:0] r_x_span_below;
    logic [RAW_W-1:0] r_y_span_above;
    logic [RAW_W-1:0] r_y_span_below;
    logic [RAW_W-1:0] r_dead_band;

    logic [DEP-1:0] r_v;
    logic [DEP:0]   w_en;
    t_axis_res      w_x_res;
    t_axis_res      w_y_res;
    logic           w_take;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_center <= CENTER_RST;
            r_y_center <= CENTER_RST;
            r_x_span_above <= SPAN_RST;
            r_x_span_below <= SPAN_RST;
            r_y_span_above <= SPAN_RST;
            r_y_span_below <= SPAN_RST;
            r_dead_band <= BAND_RST;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_X_CENTER:     r_x_center <= i_cfg_data;
                REG_Y_CENTER:     r_y_center <= i_cfg_data;
                REG_X_SPAN_ABOVE: r_x_span_above <= i_cfg_data;
                REG_X_SPAN_BELOW: r_x_span_below <= i_cfg_data;
                REG_Y_SPAN_ABOVE: r_y_span_above <= i_cfg_data;
                REG_Y_SPAN_BELOW: r_y_span_below <= i_cfg_data;
                REG_DEAD_BAND:    r_dead_band <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage enables: a stage advances when empty or when its successor does
    assign w_en[DEP] = w_take;
    for (genvar i = 0; i < DEP; i++) begin : g_en
        assign w_en[i] = !r_v[i] || w_en[i+1];
    end

    assign o_s_axis_tready = w_en[0];

    // Valid bits travel with the requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int i = 0; i < DEP; i++) begin
                if (w_en[i]) begin
                    r_v[i] <= (i == 0) ? i_s_axis_tvalid : r_v[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // X lane: byte_low plus low nibble of byte_mid
    sac_lane #(
        .FULL_SCALE (FULL_SCALE)
    ) u_lane_x (
        .i_clk        (i_clk),
        .i_en         (w_en[DEP-1:0]),
        .i_raw        (i_s_axis_tdata[11:0]),
        .i_center     (r_x_center),
        .i_span_above (r_x_span_above),
        .i_span_below (r_x_span_below),
        .i_band       (r_dead_band),
        .o_res        (w_x_res)
    );

    // Y lane: high nibble of byte_mid plus byte_high
    sac_lane #(
        .FULL_SCALE (FULL_SCALE)
    ) u_lane_y (
        .i_clk        (i_clk),
        .i_en         (w_en[DEP-1:0]),
        .i_raw        (i_s_axis_tdata[23:12]),
        .i_center     (r_y_center),
        .i_span_above (r_y_span_above),
        .i_span_below (r_y_span_below),
        .i_band       (r_dead_band),
        .o_res        (w_y_res)
    );

    // Combine both lanes into the output register
    sac_merge #(
        .FULL_SCALE (FULL_SCALE)
    ) u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_v[DEP-1]),
        .i_x             (w_x_res),
        .i_y             (w_y_res),
        .o_take          (w_take),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

`ifndef SYNTHESIS
    localparam logic signed [OUT_W-1:0] FS_POS = OUT_W'(FULL_SCALE);
    localparam logic signed [OUT_W-1:0] FS_NEG = -FS_POS;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_v[0])
        else $error("accepted request did not enter the front stage");

    a_last_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[DEP-1] && !w_take |=> r_v[DEP-1])
        else $error("last divider stage dropped a stalled request");

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[OUT_W-1:0]) <= FS_POS &&
                             $signed(o_m_axis_tdata[OUT_W-1:0]) >= FS_NEG))
        else $error("x result beyond full scale");

    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[OUT_TDATA_W-1:OUT_W]) <= FS_POS &&
                             $signed(o_m_axis_tdata[OUT_TDATA_W-1:OUT_W]) >= FS_NEG))
        else $error("y result beyond full scale");
`endif

endmodule

// ----- rtl/sac_lane.sv -----
`timescale 1ns / 1ps

module sac_lane import sac_pkg::*; #(
    parameter int FULL_SCALE = FULL_SCALE_DEF,
    localparam int QW = $clog2(FULL_SCALE + 1),
    localparam int DEP = QW + 2
) (
    input  logic             i_clk,
    input  logic [DEP-1:0]   i_en,
    input  logic [RAW_W-1:0] i_raw,
    input  logic [RAW_W-1:0] i_center,
    input  logic [RAW_W-1:0] i_span_above,
    input  logic [RAW_W-1:0] i_span_below,
    input  logic [RAW_W-1:0] i_band,
    output t_axis_res        o_res
);

    localparam int NW = RAW_W + QW;
    localparam logic [QW-1:0] FS_Q = QW'(FULL_SCALE);

    logic [RAW_W:0]   w_diff;
    logic             w_neg;
    logic [RAW_W-1:0] w_mag;
    logic [RAW_W-1:0] w_span;
    t_kind            w_kind;

    logic [RAW_W-1:0] r_mag;
    logic [RAW_W-1:0] r_span [DEP];
    logic             r_neg  [DEP];
    t_kind            r_kind [DEP];
    logic [NW-1:0]    r_rem  [1:DEP-1];
    logic [QW-1:0]    r_quo  [1:DEP-1];

    // Offset from center, its magnitude and the span on its side
    always_comb begin
        w_diff = {1'b0, i_raw} - {1'b0, i_center};
        w_neg = w_diff[RAW_W];
        w_mag = w_neg ? RAW_W'(~w_diff + 1'b1) : w_diff[RAW_W-1:0];
        w_span = (!w_neg && w_mag != '0) ? i_span_above : i_span_below;
        if (w_mag == '0 || w_mag < i_band) begin
            w_kind = K_ZERO;
        end else if (w_span == '0 || w_mag >= w_span) begin
            w_kind = K_FULL;
        end else begin
            w_kind = K_DIV;
        end
    end

    // Front stage: classify the offset
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_mag <= w_mag;
            r_span[0] <= w_span;
            r_neg[0] <= w_neg;
            r_kind[0] <= w_kind;
        end
    end

    // Multiply stage: scale the magnitude by full scale
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_rem[1] <= NW'(r_mag) * NW'(FS_Q);
            r_quo[1] <= '0;
            r_span[1] <= r_span[0];
            r_neg[1] <= r_neg[0];
            r_kind[1] <= r_kind[0];
        end
    end

    // Divider stages: one quotient bit each, most significant first
    for (genvar s = 0; s < QW; s++) begin : g_step
        localparam int J = s + 2;
        localparam int SH = QW - 1 - s;
        logic [NW-1:0] w_sub;
        logic          w_ge;

        assign w_sub = NW'(r_span[J-1]) << SH;
        assign w_ge = (r_rem[J-1] >= w_sub);

        always_ff @(posedge i_clk) begin
            if (i_en[J]) begin
                r_rem[J] <= w_ge ? (r_rem[J-1] - w_sub) : r_rem[J-1];
                r_quo[J] <= r_quo[J-1] | (QW'(w_ge) << SH);
                r_span[J] <= r_span[J-1];
                r_neg[J] <= r_neg[J-1];
                r_kind[J] <= r_kind[J-1];
            end
        end
    end

    assign o_res.neg = r_neg[DEP-1];
    assign o_res.kind = r_kind[DEP-1];
    assign o_res.quo = OUT_W'(r_quo[DEP-1]);

endmodule

// ----- rtl/sac_merge.sv -----
`timescale 1ns / 1ps

module sac_merge import sac_pkg::*; #(
    parameter int FULL_SCALE = FULL_SCALE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  t_axis_res              i_x,
    input  t_axis_res              i_y,
    output logic                   o_take,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata   // [15:0] x_out, [31:16] y_out
);

    localparam logic [OUT_W-1:0] FS_OUT = OUT_W'(FULL_SCALE);

    logic                   r_valid;
    logic [OUT_TDATA_W-1:0] r_data;
    logic [OUT_W-1:0]       w_x;
    logic [OUT_W-1:0]       w_y;

    function automatic logic [OUT_W-1:0] axis_out(input t_axis_res res);
        logic [OUT_W-1:0] mag;
        case (res.kind)
            K_ZERO:  mag = '0;
            K_FULL:  mag = FS_OUT;
            K_DIV:   mag = res.quo;
            default: mag = '0;
        endcase
        return res.neg ? (~mag + 1'b1) : mag;
    endfunction

    // Apply sign and saturation for both lanes
    assign w_x = axis_out(i_x);
    assign w_y = axis_out(i_y);

    // Load the output register whenever it is empty or being drained
    assign o_take = !r_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_data <= {w_y, w_x};
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata = r_data;

endmodule
